>>> src/wmb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package wmb_pkg;

   // default sizing
   localparam int DEF_MAX_TABLE_SIZE = 65537;
   localparam int DEF_MAX_BACKENDS   = 64;

   // fixed field widths
   localparam int REQ_W    = 2;
   localparam int WEIGHT_W = 16;
   localparam int HASH_W   = 64;
   localparam int SIZE_W   = 17;
   localparam int SCORE_W  = 34;
   localparam int PASS_W   = 18;
   localparam int STATUS_W = 3;
   localparam int IDX_W    = 6;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 17'd65537;
   localparam logic [SIZE_W-1:0] MIN_SIZE   = 17'd2;
   localparam int                SIZE_LIMIT = 131071;

   typedef enum logic [REQ_W-1:0] {
      OP_CLEAR  = 2'd0,
      OP_APPEND = 2'd1,
      OP_BUILD  = 2'd2,
      OP_LOOKUP = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK         = 3'd0,
      STAT_NO_BACKEND = 3'd1,
      STAT_ABORT      = 3'd2,
      STAT_NOT_BUILT  = 3'd3,
      STAT_FULL       = 3'd4
   } status_type;

   // request as queued between front and back
   typedef struct packed {
      op_type              op;
      logic [WEIGHT_W-1:0] weight;
      logic [HASH_W-1:0]   hash_a;   // offset hash on append, request hash on lookup
      logic [HASH_W-1:0]   hash_b;   // skip hash
   } item_type;

   // backend record: weight with offset and skip
   typedef struct packed {
      logic [WEIGHT_W-1:0] weight;
      logic [SIZE_W-1:0]   offset;
      logic [SIZE_W-1:0]   skip;
   } bk_entry_type;

   typedef enum logic [4:0] {
      BK_IDLE,
      BK_AP_OFF,
      BK_AP_SKIP,
      BK_LK_MOD,
      BK_LK_RD,
      BK_RD_ISSUE,
      BK_RD_CHK,
      BK_RD_OFF,
      BK_RD_SKIP,
      BK_SO_I,
      BK_SO_ILAT,
      BK_SO_J,
      BK_SO_CMP,
      BK_CLR,
      BK_FL_RANK,
      BK_FL_LAT,
      BK_FL_CMP,
      BK_FL_PRB,
      BK_FL_CHK
   } state_type;

endpackage
`default_nettype wire

>>> src/wmb_front.sv
`timescale 1ns / 1ps
`default_nettype none
module wmb_front (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output logic                              busy,
   input  wire logic [wmb_pkg::REQ_W-1:0]    req_type,
   input  wire logic [wmb_pkg::WEIGHT_W-1:0] req_weight,
   input  wire logic [wmb_pkg::HASH_W-1:0]   req_offset_hash,
   input  wire logic [wmb_pkg::HASH_W-1:0]   req_skip_hash,
   input  wire logic [wmb_pkg::HASH_W-1:0]   req_request_hash,
   output logic                              item_valid,
   output wmb_pkg::item_type                 item,
   input  wire logic                         item_pop
);
   import wmb_pkg::*;

   item_type   q_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;
   logic       push;
   item_type   cls;

   // classify request: pick the hash that the operation uses
   always_comb begin
      cls.op     = op_type'(req_type);
      cls.weight = req_weight;
      cls.hash_b = req_skip_hash;
      unique case (op_type'(req_type))
         OP_LOOKUP: cls.hash_a = req_request_hash;
         OP_APPEND: cls.hash_a = req_offset_hash;
         default:   cls.hash_a = req_offset_hash;
      endcase
   end

   assign busy       = (cnt_ff == 2'd2);
   assign push       = start && !busy;
   assign item_valid = (cnt_ff != 2'd0);
   assign item       = q_ff[rd_ff];

   // advance queue pointers
   always_comb begin
      wr_in  = push ? !wr_ff : wr_ff;
      rd_in  = item_pop ? !rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, item_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
      end
   end

   // hold request payload
   always_ff @(posedge clock) begin
      if (push) q_ff[wr_ff] <= cls;
   end

endmodule
`default_nettype wire

>>> src/wmb_mod.sv
`timescale 1ns / 1ps
`default_nettype none
module wmb_mod (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       go,
   input  wire logic [wmb_pkg::HASH_W-1:0] dividend,
   input  wire logic [wmb_pkg::SIZE_W-1:0] divisor,
   output logic                            busy,
   output logic                            done,
   output logic [wmb_pkg::SIZE_W-1:0]      remainder
);
   import wmb_pkg::*;

   localparam int CW = $clog2(HASH_W);

   logic [HASH_W-1:0] x_ff, x_in;
   logic [SIZE_W-1:0] m_ff, m_in;
   logic [SIZE_W-1:0] rem_ff, rem_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic              run_ff, run_in;
   logic              done_ff, done_in;
   logic [SIZE_W:0]   trial;
   logic              last;

   assign trial = {rem_ff, x_ff[HASH_W-1]};
   assign last  = (cnt_ff == CW'(HASH_W - 1));

   // one quotient bit per cycle, restoring
   always_comb begin
      x_in    = x_ff;
      m_in    = m_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (go) begin
         x_in   = dividend;
         m_in   = divisor;
         rem_in = '0;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         x_in   = {x_ff[HASH_W-2:0], 1'b0};
         rem_in = (trial >= {1'b0, m_ff}) ? SIZE_W'(trial - {1'b0, m_ff}) : SIZE_W'(trial);
         cnt_in = cnt_ff + CW'(1);
         if (last) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      m_ff   <= m_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
   end

   assign busy      = run_ff;
   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule
`default_nettype wire

>>> src/wmb_back.sv
`timescale 1ns / 1ps
`default_nettype none
module wmb_back #(
   parameter int MAX_TABLE_SIZE = wmb_pkg::DEF_MAX_TABLE_SIZE,
   parameter int MAX_BACKENDS   = wmb_pkg::DEF_MAX_BACKENDS
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         item_valid,
   input  wire wmb_pkg::item_type            item,
   output logic                              item_pop,
   input  wire logic                         csr_we,
   input  wire logic [wmb_pkg::SIZE_W-1:0]   csr_data,
   output logic                              rsp_strobe,
   output logic [wmb_pkg::STATUS_W-1:0]      rsp_status,
   output logic [wmb_pkg::IDX_W-1:0]         rsp_backend_index
);
   import wmb_pkg::*;

   localparam int BI_W    = (MAX_BACKENDS > 1) ? $clog2(MAX_BACKENDS) : 1;
   localparam int CNT_W   = $clog2(MAX_BACKENDS + 1);
   localparam int SLOT_AW = $clog2(MAX_TABLE_SIZE);
   localparam int SLOT_W  = BI_W + 1;
   localparam int CAP     = (MAX_TABLE_SIZE > SIZE_LIMIT) ? SIZE_LIMIT : MAX_TABLE_SIZE;
   localparam logic [SIZE_W-1:0] SIZE_CAP = SIZE_W'(CAP);
   localparam logic [CNT_W-1:0]  BK_FULL  = CNT_W'(MAX_BACKENDS);

   typedef struct packed {
      logic [BI_W-1:0]     backend;
      logic [SIZE_W-1:0]   step;
      logic [WEIGHT_W-1:0] weight;
      logic [SIZE_W-1:0]   pos;
      logic [SCORE_W-1:0]  score;
   } rank_entry_type;

   // memories
   bk_entry_type   bk_mem   [MAX_BACKENDS];
   bk_entry_type   key_mem  [MAX_BACKENDS];
   rank_entry_type rank_mem [MAX_BACKENDS];
   logic [SLOT_W-1:0] slot_mem [MAX_TABLE_SIZE];
   logic [MAX_BACKENDS-1:0] elig_ff;

   bk_entry_type   bk_rd_ff, key_rd_ff;
   rank_entry_type rank_rd_ff;
   logic [SLOT_W-1:0] slot_rd_ff;

   // memory controls
   logic              bk_we, key_we, rank_we, slot_we, elig_we, elig_val;
   logic [BI_W-1:0]   bk_raddr, key_raddr, rank_waddr;
   logic [SLOT_AW-1:0] slot_addr_r, slot_addr_w;
   bk_entry_type      bk_wdata, key_wdata;
   rank_entry_type    rank_wdata;
   logic [SLOT_W-1:0] slot_wdata;

   // divider
   logic              mod_go, mod_busy, mod_done;
   logic [HASH_W-1:0] mod_x;
   logic [SIZE_W-1:0] mod_m, mod_rem;

   // control and datapath registers
   state_type         state_ff, state_in;
   logic [SIZE_W-1:0] size_raw_ff, size_raw_in;
   logic              ready_ff, ready_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  n_ff, n_in;
   logic [CNT_W-1:0]  i_ff, i_in;
   logic [CNT_W-1:0]  j_ff, j_in;
   logic [CNT_W-1:0]  r_ff, r_in;
   logic [BI_W-1:0]   rank_ff, rank_in;
   logic [WEIGHT_W-1:0] largest_ff, largest_in;
   logic [SIZE_W-1:0] filled_ff, filled_in;
   logic [PASS_W-1:0] pass_ff, pass_in;
   logic [SIZE_W-1:0] probes_ff, probes_in;
   logic [SIZE_W-1:0] pos_ff, pos_in;
   logic [SIZE_W-1:0] off_ff, off_in;
   logic [SCORE_W-1:0] prod_ff, prod_in;
   bk_entry_type      hold_ff, hold_in;
   bk_entry_type      keyi_ff, keyi_in;
   rank_entry_type    ent_ff, ent_in;
   item_type          item_ff, item_in;
   logic              rsp_strobe_ff, rsp_strobe_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [IDX_W-1:0]  rsp_idx_ff, rsp_idx_in;

   // shared conditions
   logic [SIZE_W-1:0] size;
   logic [BI_W-1:0]   i_idx, j_idx, r_idx;
   logic              i_end, j_end, r_end, key_less, claim, in_fill;
   logic [PASS_W-1:0] pass_next;
   logic              pass_over, probe_last, fill_last;
   logic [SIZE_W:0]   pos_sum;
   logic [SIZE_W-1:0] pos_adv;

   wmb_mod u_mod (
      .clock     (clock),
      .reset     (reset),
      .go        (mod_go),
      .dividend  (mod_x),
      .divisor   (mod_m),
      .busy      (mod_busy),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   // clamp table size into range
   assign size = (size_raw_ff < MIN_SIZE) ? MIN_SIZE :
                 ((size_raw_ff > SIZE_CAP) ? SIZE_CAP : size_raw_ff);

   assign i_idx      = i_ff[BI_W-1:0];
   assign j_idx      = j_ff[BI_W-1:0];
   assign r_idx      = r_ff[BI_W-1:0];
   assign i_end      = (i_ff == count_ff);
   assign j_end      = (j_ff == count_ff);
   assign r_end      = (r_ff == n_ff);
   assign key_less   = {key_rd_ff.offset, key_rd_ff.skip, j_idx} <
                       {keyi_ff.offset, keyi_ff.skip, i_idx};
   assign claim      = !(prod_ff < ent_ff.score);
   assign pass_next  = pass_ff + PASS_W'(1);
   assign pass_over  = (pass_next > {size, 1'b0});
   assign probe_last = ((probes_ff + SIZE_W'(1)) >= size);
   assign fill_last  = ((filled_ff + SIZE_W'(1)) == size);
   assign pos_sum    = {1'b0, pos_ff} + {1'b0, ent_ff.step};
   assign pos_adv    = (pos_sum >= {1'b0, size}) ? SIZE_W'(pos_sum - {1'b0, size})
                                                 : SIZE_W'(pos_sum);
   assign in_fill    = (state_ff == BK_FL_RANK) || (state_ff == BK_FL_LAT) ||
                       (state_ff == BK_FL_CMP) || (state_ff == BK_FL_PRB) ||
                       (state_ff == BK_FL_CHK);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (item_valid) begin
               unique case (item.op)
                  OP_CLEAR:  state_in = BK_IDLE;
                  OP_APPEND: state_in = (count_ff >= BK_FULL) ? BK_IDLE : BK_AP_OFF;
                  OP_BUILD:  state_in = BK_RD_ISSUE;
                  OP_LOOKUP: state_in = ready_ff ? BK_LK_MOD : BK_IDLE;
                  default:   state_in = BK_IDLE;
               endcase
            end
         end
         BK_AP_OFF:   if (mod_done) state_in = BK_AP_SKIP;
         BK_AP_SKIP:  if (mod_done) state_in = BK_IDLE;
         BK_LK_MOD:   if (mod_done) state_in = BK_LK_RD;
         BK_LK_RD:    state_in = BK_IDLE;
         BK_RD_ISSUE: begin
            if (i_end) state_in = (n_ff == '0) ? BK_IDLE : BK_SO_I;
            else state_in = BK_RD_CHK;
         end
         BK_RD_CHK:   state_in = (bk_rd_ff.weight == '0) ? BK_RD_ISSUE : BK_RD_OFF;
         BK_RD_OFF:   if (mod_done) state_in = BK_RD_SKIP;
         BK_RD_SKIP:  if (mod_done) state_in = BK_RD_ISSUE;
         BK_SO_I: begin
            if (i_end) state_in = BK_CLR;
            else if (elig_ff[i_idx]) state_in = BK_SO_ILAT;
         end
         BK_SO_ILAT:  state_in = BK_SO_J;
         BK_SO_J: begin
            if (j_end) state_in = BK_SO_I;
            else if (elig_ff[j_idx]) state_in = BK_SO_CMP;
         end
         BK_SO_CMP:   state_in = BK_SO_J;
         BK_CLR:      if (pos_ff == size - SIZE_W'(1)) state_in = BK_FL_RANK;
         BK_FL_RANK: begin
            if (r_end) begin
               if (pass_over) state_in = BK_IDLE;
            end else begin
               state_in = BK_FL_LAT;
            end
         end
         BK_FL_LAT:   state_in = BK_FL_CMP;
         BK_FL_CMP:   state_in = claim ? BK_FL_PRB : BK_FL_RANK;
         BK_FL_PRB:   state_in = BK_FL_CHK;
         BK_FL_CHK: begin
            if (slot_rd_ff != '0) state_in = probe_last ? BK_IDLE : BK_FL_PRB;
            else state_in = fill_last ? BK_IDLE : BK_FL_RANK;
         end
         default:     state_in = BK_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      item_pop      = 1'b0;
      bk_we         = 1'b0;
      key_we        = 1'b0;
      rank_we       = 1'b0;
      slot_we       = 1'b0;
      elig_we       = 1'b0;
      elig_val      = 1'b0;
      bk_raddr      = i_idx;
      key_raddr     = i_idx;
      rank_waddr    = r_idx;
      slot_addr_r   = SLOT_AW'(pos_ff);
      slot_addr_w   = SLOT_AW'(pos_ff);
      bk_wdata      = '{weight: item_ff.weight, offset: off_ff, skip: mod_rem + SIZE_W'(1)};
      key_wdata     = '{weight: hold_ff.weight, offset: off_ff, skip: mod_rem};
      rank_wdata    = ent_ff;
      slot_wdata    = '0;
      mod_go        = 1'b0;
      mod_x         = item.hash_a;
      mod_m         = size;
      size_raw_in   = size_raw_ff;
      ready_in      = ready_ff;
      count_in      = count_ff;
      n_in          = n_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      r_in          = r_ff;
      rank_in       = rank_ff;
      largest_in    = largest_ff;
      filled_in     = filled_ff;
      pass_in       = pass_ff;
      probes_in     = probes_ff;
      pos_in        = pos_ff;
      off_in        = off_ff;
      prod_in       = prod_ff;
      hold_in       = hold_ff;
      keyi_in       = keyi_ff;
      ent_in        = ent_ff;
      item_in       = item_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_idx_in    = rsp_idx_ff;

      // register write drops any built table, except one whose fill completes as it is written
      if (csr_we) begin
         size_raw_in = csr_data;
         ready_in    = 1'b0;
      end

      unique case (state_ff)
         BK_IDLE: begin
            if (item_valid) begin
               item_pop = 1'b1;
               item_in  = item;
               unique case (item.op)
                  OP_CLEAR: begin
                     count_in      = '0;
                     ready_in      = 1'b0;
                     rsp_strobe_in = 1'b1;
                     rsp_status_in = STAT_OK;
                     rsp_idx_in    = '0;
                  end
                  OP_APPEND: begin
                     if (count_ff >= BK_FULL) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = STAT_FULL;
                        rsp_idx_in    = '0;
                     end else begin
                        mod_go = 1'b1;
                     end
                  end
                  OP_BUILD: begin
                     ready_in   = 1'b0;
                     largest_in = '0;
                     i_in       = '0;
                     n_in       = '0;
                  end
                  OP_LOOKUP: begin
                     if (ready_ff) begin
                        mod_go = 1'b1;
                     end else begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = STAT_NOT_BUILT;
                        rsp_idx_in    = '0;
                     end
                  end
                  default: ;
               endcase
            end
         end
         BK_AP_OFF: begin
            if (mod_done) begin
               off_in = mod_rem;
               mod_go = 1'b1;
               mod_x  = item_ff.hash_b;
               mod_m  = size - SIZE_W'(1);
            end
         end
         BK_AP_SKIP: begin
            if (mod_done) begin
               bk_we         = 1'b1;
               count_in      = count_ff + CNT_W'(1);
               rsp_strobe_in = 1'b1;
               rsp_status_in = STAT_OK;
               rsp_idx_in    = IDX_W'(count_ff);
            end
         end
         BK_LK_MOD: begin
            slot_addr_r = SLOT_AW'(mod_rem);
         end
         BK_LK_RD: begin
            rsp_strobe_in = 1'b1;
            if (slot_rd_ff == '0) begin
               rsp_status_in = STAT_NOT_BUILT;
               rsp_idx_in    = '0;
            end else begin
               rsp_status_in = STAT_OK;
               rsp_idx_in    = IDX_W'(slot_rd_ff - SLOT_W'(1));
            end
         end
         BK_RD_ISSUE: begin
            if (i_end) begin
               i_in = '0;
               if (n_ff == '0) begin
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = STAT_NO_BACKEND;
                  rsp_idx_in    = '0;
               end
            end
         end
         BK_RD_CHK: begin
            if (bk_rd_ff.weight == '0) begin
               elig_we  = 1'b1;
               elig_val = 1'b0;
               i_in     = i_ff + CNT_W'(1);
            end else begin
               hold_in = bk_rd_ff;
               if (bk_rd_ff.weight > largest_ff) largest_in = bk_rd_ff.weight;
               mod_go = 1'b1;
               mod_x  = HASH_W'(bk_rd_ff.offset);
            end
         end
         BK_RD_OFF: begin
            if (mod_done) begin
               off_in = mod_rem;
               mod_go = 1'b1;
               mod_x  = HASH_W'(hold_ff.skip);
            end
         end
         BK_RD_SKIP: begin
            if (mod_done) begin
               key_we   = 1'b1;
               elig_we  = 1'b1;
               elig_val = 1'b1;
               n_in     = n_ff + CNT_W'(1);
               i_in     = i_ff + CNT_W'(1);
            end
         end
         BK_SO_I: begin
            if (i_end) begin
               pos_in = '0;
            end else if (!elig_ff[i_idx]) begin
               i_in = i_ff + CNT_W'(1);
            end
         end
         BK_SO_ILAT: begin
            keyi_in = key_rd_ff;
            j_in    = '0;
            rank_in = '0;
         end
         BK_SO_J: begin
            key_raddr = j_idx;
            if (j_end) begin
               rank_we    = 1'b1;
               rank_waddr = rank_ff;
               rank_wdata = '{backend: i_idx, step: keyi_ff.skip, weight: keyi_ff.weight,
                              pos: keyi_ff.offset, score: '0};
               i_in       = i_ff + CNT_W'(1);
            end else if (!elig_ff[j_idx]) begin
               j_in = j_ff + CNT_W'(1);
            end
         end
         BK_SO_CMP: begin
            if (key_less) rank_in = rank_ff + BI_W'(1);
            j_in = j_ff + CNT_W'(1);
         end
         BK_CLR: begin
            slot_we = 1'b1;
            if (pos_ff == size - SIZE_W'(1)) begin
               filled_in = '0;
               pass_in   = PASS_W'(1);
               r_in      = '0;
            end else begin
               pos_in = pos_ff + SIZE_W'(1);
            end
         end
         BK_FL_RANK: begin
            if (r_end) begin
               pass_in = pass_next;
               r_in    = '0;
               if (pass_over) begin
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = STAT_ABORT;
                  rsp_idx_in    = '0;
               end
            end
         end
         BK_FL_LAT: begin
            ent_in  = rank_rd_ff;
            prod_in = {{(SCORE_W-PASS_W){1'b0}}, pass_ff} *
                      {{(SCORE_W-WEIGHT_W){1'b0}}, rank_rd_ff.weight};
         end
         BK_FL_CMP: begin
            if (claim) begin
               ent_in.score = ent_ff.score + {{(SCORE_W-WEIGHT_W){1'b0}}, largest_ff};
               probes_in    = '0;
               pos_in       = ent_ff.pos;
            end else begin
               r_in = r_ff + CNT_W'(1);
            end
         end
         BK_FL_PRB: ;
         BK_FL_CHK: begin
            if (slot_rd_ff != '0) begin
               if (probe_last) begin
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = STAT_ABORT;
                  rsp_idx_in    = '0;
               end else begin
                  probes_in = probes_ff + SIZE_W'(1);
                  pos_in    = pos_adv;
               end
            end else begin
               slot_we        = 1'b1;
               slot_wdata     = {1'b0, ent_ff.backend} + SLOT_W'(1);
               rank_we        = 1'b1;
               rank_wdata     = ent_ff;
               rank_wdata.pos = pos_adv;
               filled_in      = filled_ff + SIZE_W'(1);
               if (fill_last) begin
                  ready_in      = 1'b1;
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = STAT_OK;
                  rsp_idx_in    = '0;
               end else begin
                  r_in = r_ff + CNT_W'(1);
               end
            end
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BK_IDLE;
         size_raw_ff   <= SIZE_RESET;
         ready_ff      <= 1'b0;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         size_raw_ff   <= size_raw_in;
         ready_ff      <= ready_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      n_ff          <= n_in;
      i_ff          <= i_in;
      j_ff          <= j_in;
      r_ff          <= r_in;
      rank_ff       <= rank_in;
      largest_ff    <= largest_in;
      filled_ff     <= filled_in;
      pass_ff       <= pass_in;
      probes_ff     <= probes_in;
      pos_ff        <= pos_in;
      off_ff        <= off_in;
      prod_ff       <= prod_in;
      hold_ff       <= hold_in;
      keyi_ff       <= keyi_in;
      ent_ff        <= ent_in;
      item_ff       <= item_in;
      rsp_status_ff <= rsp_status_in;
      rsp_idx_ff    <= rsp_idx_in;
   end

   // backend list memory
   always_ff @(posedge clock) begin
      if (bk_we) bk_mem[count_ff[BI_W-1:0]] <= bk_wdata;
      bk_rd_ff <= bk_mem[bk_raddr];
   end

   // reduced sort keys
   always_ff @(posedge clock) begin
      if (key_we) key_mem[i_idx] <= key_wdata;
      key_rd_ff <= key_mem[key_raddr];
   end

   // eligibility bits
   always_ff @(posedge clock) begin
      if (elig_we) elig_ff[i_idx] <= elig_val;
   end

   // per-rank probe state
   always_ff @(posedge clock) begin
      if (rank_we) rank_mem[rank_waddr] <= rank_wdata;
      rank_rd_ff <= rank_mem[r_idx];
   end

   // slot table
   always_ff @(posedge clock) begin
      if (slot_we) slot_mem[slot_addr_w] <= slot_wdata;
      slot_rd_ff <= slot_mem[slot_addr_r];
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_backend_index = rsp_idx_ff;

   a_mod_idle: assert property (@(posedge clock) disable iff (reset)
      mod_go |-> !mod_busy) else $error("divider restarted while running");
   a_ready_count: assert property (@(posedge clock) disable iff (reset)
      ready_ff |-> (count_ff != '0)) else $error("table built with empty list");
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      in_fill |-> (filled_ff < size)) else $error("fill count reached size in fill");
   a_pass_bound: assert property (@(posedge clock) disable iff (reset)
      in_fill |-> ((pass_ff != '0) && (pass_ff <= {size, 1'b0})))
      else $error("pass number out of bound");

endmodule
`default_nettype wire

>>> src/weighted_maglev_table_balancer.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Handshake                  Payload
// request   in         start && !busy             req_type, req_weight, req_*_hash
// response  out        rsp_strobe, one cycle      rsp_status, rsp_backend_index
// config    in         csr_valid && csr_ready     csr_table_size
//
// Requests enter a two-deep queue; busy is high while it is full.
// Clear, append to a full list and lookup of an unbuilt table answer from the idle state.
// Lookup runs the one-bit-per-cycle divider once and append runs it twice.
// Build reduces each backend's offset and skip with the divider, ranks backends by
// comparing each pair, clears the slot table, then fills it in passes with probing.
// Synchronous reset clears control state; the receiver cannot stall responses.
module weighted_maglev_table_balancer #(
   parameter int MAX_TABLE_SIZE = wmb_pkg::DEF_MAX_TABLE_SIZE,
   parameter int MAX_BACKENDS   = wmb_pkg::DEF_MAX_BACKENDS
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output logic                              busy,
   input  wire logic [wmb_pkg::REQ_W-1:0]    req_type,
   input  wire logic [wmb_pkg::WEIGHT_W-1:0] req_weight,
   input  wire logic [wmb_pkg::HASH_W-1:0]   req_offset_hash,
   input  wire logic [wmb_pkg::HASH_W-1:0]   req_skip_hash,
   input  wire logic [wmb_pkg::HASH_W-1:0]   req_request_hash,
   output logic                              rsp_strobe,
   output logic [wmb_pkg::STATUS_W-1:0]      rsp_status,
   output logic [wmb_pkg::IDX_W-1:0]         rsp_backend_index,
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic [wmb_pkg::SIZE_W-1:0]   csr_table_size
);
   import wmb_pkg::*;

   logic     item_valid;
   item_type item;
   logic     item_pop;

   assign csr_ready = 1'b1;

   wmb_front u_front (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_type         (req_type),
      .req_weight       (req_weight),
      .req_offset_hash  (req_offset_hash),
      .req_skip_hash    (req_skip_hash),
      .req_request_hash (req_request_hash),
      .item_valid       (item_valid),
      .item             (item),
      .item_pop         (item_pop)
   );

   wmb_back #(
      .MAX_TABLE_SIZE (MAX_TABLE_SIZE),
      .MAX_BACKENDS   (MAX_BACKENDS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .item_valid        (item_valid),
      .item              (item),
      .item_pop          (item_pop),
      .csr_we            (csr_valid && csr_ready),
      .csr_data          (csr_table_size),
      .rsp_strobe        (rsp_strobe),
      .rsp_status        (rsp_status),
      .rsp_backend_index (rsp_backend_index)
   );

endmodule
`default_nettype wire
